### src/cidft_pkg.sv
// ============================================================================
// cidft_pkg
// Shared types and constants for the CAN identifier frequency table.
// ============================================================================
package cidft_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int USED_W      = $clog2(TABLE_DEPTH + 1);

  localparam int ID_W        = 29;
  localparam int COUNT_W     = 32;
  localparam int DLEN_W      = 4;
  localparam int BYTE_W      = 8;
  localparam int VOLT_W      = 16;
  localparam int TIME_W      = 32;
  localparam int INTERVAL_W  = 16;
  localparam int STATUS_W    = 3;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = ID_W;

  localparam logic [COUNT_W-1:0]    COUNT_MAX        = '1;
  localparam logic [DLEN_W-1:0]     MIN_VOLT_LEN     = DLEN_W'(4);
  localparam logic [ID_W-1:0]       STATUS_ID_RESET  = ID_W'(32'hE000);
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET   = INTERVAL_W'(500);

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STATUS_ID       = 1'b0,
    CFG_REPORT_INTERVAL = 1'b1
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_COUNTED    = 3'd0,
    STAT_NEW        = 3'd1,
    STAT_DROPPED    = 3'd2,
    STAT_READ_OK    = 3'd3,
    STAT_READ_EMPTY = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEARCH
  } ctrl_state_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [COUNT_W-1:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    entry_t             wdata;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

  typedef struct packed {
    status_t             status;
    logic [IDX_W-1:0]    index;
    logic [ID_W-1:0]     id;
    logic [COUNT_W-1:0]  count;
    logic [USED_W-1:0]   distinct;
  } result_t;

endpackage

### src/can_id_frequency_table_top.sv
// ============================================================================
// can_id_frequency_table_top
// CAN identifier frequency table with pack voltage capture.
// ============================================================================
// A transaction is taken when start is high and busy is low. A record frame
// is searched through the table RAM one entry per cycle, with the read of
// the next entry issued while the current one is compared, so busy stays
// high until a hit or the last entry in use has been compared, covering at
// most TABLE_DEPTH entries; a record on an empty table does not raise busy.
// A read transaction raises busy for a slot in use and not otherwise. Each
// result is shown on the out_ ports for exactly one cycle with out_valid,
// the cycle after the transaction completes; it cannot be held off and is
// lost if not sampled.
// Configuration writes are taken at any edge with cfg_we high.
module can_id_frequency_table_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [cidft_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cidft_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_opcode,
  input  logic [cidft_pkg::ID_W-1:0]            in_frame_id,
  input  logic [cidft_pkg::DLEN_W-1:0]          in_data_length,
  input  logic [cidft_pkg::BYTE_W-1:0]          in_voltage_high_byte,
  input  logic [cidft_pkg::BYTE_W-1:0]          in_voltage_low_byte,
  input  logic [cidft_pkg::TIME_W-1:0]          in_timestamp_ms,
  input  logic [cidft_pkg::IDX_W-1:0]           in_read_index,
  output logic                                  out_valid,
  output logic [cidft_pkg::STATUS_W-1:0]        out_status,
  output logic [cidft_pkg::IDX_W-1:0]           out_entry_index,
  output logic [cidft_pkg::ID_W-1:0]            out_entry_id,
  output logic [cidft_pkg::COUNT_W-1:0]         out_entry_count,
  output logic [cidft_pkg::USED_W-1:0]          out_distinct_ids,
  output logic [cidft_pkg::VOLT_W-1:0]          out_pack_voltage_deci,
  output logic                                  out_voltage_captured,
  output logic                                  out_voltage_report
);

  cidft_pkg::ram_req_t              ram_req;
  logic [cidft_pkg::ENTRY_W-1:0]    ram_rdata;
  cidft_pkg::result_t               res;
  logic                             fire;

  assign fire = start && !busy;

  cidft_ram #(
    .WIDTH (cidft_pkg::ENTRY_W),
    .DEPTH (cidft_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  cidft_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .opcode     (in_opcode),
    .frame_id   (in_frame_id),
    .read_index (in_read_index),
    .busy       (busy),
    .ram_req    (ram_req),
    .ram_rdata  (cidft_pkg::entry_t'(ram_rdata)),
    .res_valid  (out_valid),
    .res        (res)
  );

  cidft_volt u_volt (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .fire              (fire),
    .opcode            (in_opcode),
    .frame_id          (in_frame_id),
    .data_length       (in_data_length),
    .voltage_high_byte (in_voltage_high_byte),
    .voltage_low_byte  (in_voltage_low_byte),
    .timestamp_ms      (in_timestamp_ms),
    .voltage           (out_pack_voltage_deci),
    .captured          (out_voltage_captured),
    .report            (out_voltage_report)
  );

  assign out_status       = res.status;
  assign out_entry_index  = res.index;
  assign out_entry_id     = res.id;
  assign out_entry_count  = res.count;
  assign out_distinct_ids = res.distinct;

endmodule

### src/cidft_ram.sv
// ============================================================================
// cidft_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ============================================================================
module cidft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/cidft_volt.sv
// ============================================================================
// cidft_volt
// Configuration registers, pack voltage capture and report throttling.
// ============================================================================
module cidft_volt (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [cidft_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cidft_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                  fire,
  input  logic                                  opcode,
  input  logic [cidft_pkg::ID_W-1:0]            frame_id,
  input  logic [cidft_pkg::DLEN_W-1:0]          data_length,
  input  logic [cidft_pkg::BYTE_W-1:0]          voltage_high_byte,
  input  logic [cidft_pkg::BYTE_W-1:0]          voltage_low_byte,
  input  logic [cidft_pkg::TIME_W-1:0]          timestamp_ms,
  output logic [cidft_pkg::VOLT_W-1:0]          voltage,
  output logic                                  captured,
  output logic                                  report
);

  logic [cidft_pkg::ID_W-1:0]       status_id_r;
  logic [cidft_pkg::INTERVAL_W-1:0] interval_r;
  logic [cidft_pkg::VOLT_W-1:0]     last_volt_r;
  logic [cidft_pkg::TIME_W-1:0]     last_rep_r;
  logic                             cap_r;
  logic                             rep_r;

  logic                             cap_hit;
  logic                             elapsed_ok;
  logic [cidft_pkg::TIME_W-1:0]     elapsed;

  assign cap_hit = (opcode == cidft_pkg::OP_RECORD) && (frame_id == status_id_r) &&
                   (data_length >= cidft_pkg::MIN_VOLT_LEN);
  assign elapsed    = timestamp_ms - last_rep_r;
  assign elapsed_ok = elapsed >= cidft_pkg::TIME_W'(interval_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_id_r <= cidft_pkg::STATUS_ID_RESET;
      interval_r  <= cidft_pkg::INTERVAL_RESET;
      last_volt_r <= '0;
      last_rep_r  <= '0;
      cap_r       <= 1'b0;
      rep_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cidft_pkg::cfg_reg_t'(cfg_index))
          cidft_pkg::CFG_STATUS_ID:       status_id_r <= cfg_wdata;
          cidft_pkg::CFG_REPORT_INTERVAL: interval_r  <= cfg_wdata[cidft_pkg::INTERVAL_W-1:0];
          default: ;
        endcase
      end
      if (fire) begin
        cap_r <= cap_hit;
        rep_r <= cap_hit && elapsed_ok;
        if (cap_hit) begin
          last_volt_r <= {voltage_high_byte, voltage_low_byte};
          if (elapsed_ok) begin
            last_rep_r <= timestamp_ms;
          end
        end
      end
    end
  end

  assign voltage  = last_volt_r;
  assign captured = cap_r;
  assign report   = rep_r;

endmodule

### src/cidft_ctrl.sv
// ============================================================================
// cidft_ctrl
// Table sequencer: linear search, count update, append and slot read.
// ============================================================================
module cidft_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              opcode,
  input  logic [cidft_pkg::ID_W-1:0]        frame_id,
  input  logic [cidft_pkg::IDX_W-1:0]       read_index,
  output logic                              busy,
  output cidft_pkg::ram_req_t               ram_req,
  input  cidft_pkg::entry_t                 ram_rdata,
  output logic                              res_valid,
  output cidft_pkg::result_t                res
);

  cidft_pkg::ctrl_state_t             state_r, state_nxt;
  logic [cidft_pkg::ID_W-1:0]         fid_r, fid_nxt;
  logic [cidft_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic [cidft_pkg::USED_W-1:0]       used_r, used_nxt;
  logic                               valid_r, valid_nxt;
  cidft_pkg::result_t                 res_r, res_nxt;

  logic                               accept;
  logic                               tbl_empty;
  logic                               tbl_full;
  logic                               rd_in_range;
  logic                               hit;
  logic                               last;
  logic [cidft_pkg::COUNT_W-1:0]      cnt_inc;
  logic [cidft_pkg::USED_W-1:0]       used_inc;

  assign accept      = start && (state_r == cidft_pkg::S_IDLE);
  assign tbl_empty   = (used_r == '0);
  assign tbl_full    = (used_r == cidft_pkg::USED_W'(cidft_pkg::TABLE_DEPTH));
  assign rd_in_range = (cidft_pkg::USED_W'(read_index) < used_r);
  assign hit         = (ram_rdata.id == fid_r);
  assign last        = ((cidft_pkg::USED_W'(idx_r) + cidft_pkg::USED_W'(1)) == used_r);
  assign cnt_inc     = (ram_rdata.count == cidft_pkg::COUNT_MAX) ? ram_rdata.count
                                                                 : ram_rdata.count + 1'b1;
  assign used_inc    = used_r + cidft_pkg::USED_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cidft_pkg::S_IDLE: begin
        if (accept) begin
          if (opcode == cidft_pkg::OP_READ) begin
            if (rd_in_range) state_nxt = cidft_pkg::S_READ;
          end else if (!tbl_empty) begin
            state_nxt = cidft_pkg::S_SEARCH;
          end
        end
      end
      cidft_pkg::S_READ:   state_nxt = cidft_pkg::S_IDLE;
      cidft_pkg::S_SEARCH: begin
        if (hit || last) state_nxt = cidft_pkg::S_IDLE;
      end
      default: state_nxt = cidft_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    fid_nxt       = fid_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    valid_nxt     = 1'b0;
    res_nxt       = res_r;
    ram_req.we    = 1'b0;
    ram_req.waddr = idx_r;
    ram_req.wdata = '0;
    ram_req.raddr = idx_r + cidft_pkg::IDX_W'(1);
    case (state_r)
      cidft_pkg::S_IDLE: begin
        if (accept) begin
          fid_nxt = frame_id;
          if (opcode == cidft_pkg::OP_READ) begin
            idx_nxt       = read_index;
            ram_req.raddr = read_index;
            if (!rd_in_range) begin
              valid_nxt = 1'b1;
              res_nxt   = '{cidft_pkg::STAT_READ_EMPTY, read_index, '0, '0, used_r};
            end
          end else if (tbl_empty) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = '0;
            ram_req.wdata = '{frame_id, cidft_pkg::COUNT_W'(1)};
            used_nxt      = used_inc;
            valid_nxt     = 1'b1;
            res_nxt       = '{cidft_pkg::STAT_NEW, '0, frame_id,
                              cidft_pkg::COUNT_W'(1), used_inc};
          end else begin
            idx_nxt       = '0;
            ram_req.raddr = '0;
          end
        end
      end
      cidft_pkg::S_READ: begin
        valid_nxt = 1'b1;
        res_nxt   = '{cidft_pkg::STAT_READ_OK, idx_r, ram_rdata.id, ram_rdata.count, used_r};
      end
      cidft_pkg::S_SEARCH: begin
        if (hit) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = idx_r;
          ram_req.wdata = '{fid_r, cnt_inc};
          valid_nxt     = 1'b1;
          res_nxt       = '{cidft_pkg::STAT_COUNTED, idx_r, fid_r, cnt_inc, used_r};
        end else if (last) begin
          valid_nxt = 1'b1;
          if (tbl_full) begin
            res_nxt = '{cidft_pkg::STAT_DROPPED, '0, '0, '0, used_r};
          end else begin
            ram_req.we    = 1'b1;
            ram_req.waddr = used_r[cidft_pkg::IDX_W-1:0];
            ram_req.wdata = '{fid_r, cidft_pkg::COUNT_W'(1)};
            used_nxt      = used_inc;
            res_nxt       = '{cidft_pkg::STAT_NEW, used_r[cidft_pkg::IDX_W-1:0], fid_r,
                              cidft_pkg::COUNT_W'(1), used_inc};
          end
        end else begin
          idx_nxt = idx_r + cidft_pkg::IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cidft_pkg::S_IDLE;
      used_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fid_r <= fid_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
  end

  assign busy      = (state_r != cidft_pkg::S_IDLE);
  assign res_valid = valid_r;
  assign res       = res_r;

endmodule

### verif/can_id_frequency_table_checker.sv
// ============================================================================
// can_id_frequency_table_checker
// Predicts and checks every result of the CAN identifier frequency table.
// ============================================================================
// Watches configuration writes and accepted transactions, keeps its own copy
// of the identifier table and voltage state, and compares each strobed
// result field by field against the oldest outstanding prediction.
module can_id_frequency_table_checker
  import cidft_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  in_opcode,
  input  logic [ID_W-1:0]       in_frame_id,
  input  logic [DLEN_W-1:0]     in_data_length,
  input  logic [BYTE_W-1:0]     in_voltage_high_byte,
  input  logic [BYTE_W-1:0]     in_voltage_low_byte,
  input  logic [TIME_W-1:0]     in_timestamp_ms,
  input  logic [IDX_W-1:0]      in_read_index,
  input  logic                  out_valid,
  input  logic [STATUS_W-1:0]   out_status,
  input  logic [IDX_W-1:0]      out_entry_index,
  input  logic [ID_W-1:0]       out_entry_id,
  input  logic [COUNT_W-1:0]    out_entry_count,
  input  logic [USED_W-1:0]     out_distinct_ids,
  input  logic [VOLT_W-1:0]     out_pack_voltage_deci,
  input  logic                  out_voltage_captured,
  input  logic                  out_voltage_report,
  output int                    fail_count,
  output int                    pending,
  output int                    checked,
  output int                    dropped,
  output int                    reports
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t             status;
    logic [IDX_W-1:0]    index;
    logic [ID_W-1:0]     id;
    logic [COUNT_W-1:0]  count;
    logic [USED_W-1:0]   distinct;
    logic [VOLT_W-1:0]   voltage;
    logic                captured;
    logic                report;
  } table_outcome_t;

  logic [ID_W-1:0]       id_tab  [TABLE_DEPTH];
  logic [COUNT_W-1:0]    cnt_tab [TABLE_DEPTH];
  int                    used_slots;
  logic [VOLT_W-1:0]     last_volt;
  logic [TIME_W-1:0]     last_report_ts;
  logic [ID_W-1:0]       status_id;
  logic [INTERVAL_W-1:0] report_interval;

  table_outcome_t expected_q[$];

  task automatic predict_table_update(
    input  logic              op,
    input  logic [ID_W-1:0]   fid,
    input  logic [DLEN_W-1:0] dlen,
    input  logic [BYTE_W-1:0] vhi,
    input  logic [BYTE_W-1:0] vlo,
    input  logic [TIME_W-1:0] now,
    input  logic [IDX_W-1:0]  ridx,
    output table_outcome_t    r
  );
    int                slot;
    bit                hit;
    logic [TIME_W-1:0] elapsed;
    r = '0;
    if (op == OP_READ) begin
      r.index = ridx;
      if (int'(ridx) < used_slots) begin
        r.status = STAT_READ_OK;
        r.id     = id_tab[ridx];
        r.count  = cnt_tab[ridx];
      end else begin
        r.status = STAT_READ_EMPTY;
      end
    end else begin
      hit  = 1'b0;
      slot = 0;
      for (int i = 0; i < used_slots; i++) begin
        if (!hit && id_tab[i] == fid) begin
          hit  = 1'b1;
          slot = i;
        end
      end
      if (hit) begin
        if (cnt_tab[slot] != COUNT_MAX) cnt_tab[slot] = cnt_tab[slot] + 1'b1;
        r.status = STAT_COUNTED;
        r.index  = IDX_W'(slot);
        r.id     = fid;
        r.count  = cnt_tab[slot];
      end else if (used_slots < TABLE_DEPTH) begin
        id_tab[used_slots]  = fid;
        cnt_tab[used_slots] = COUNT_W'(1);
        r.status = STAT_NEW;
        r.index  = IDX_W'(used_slots);
        r.id     = fid;
        r.count  = COUNT_W'(1);
        used_slots++;
      end else begin
        r.status = STAT_DROPPED;
      end
      if (fid == status_id && dlen >= MIN_VOLT_LEN) begin
        last_volt  = {vhi, vlo};
        r.captured = 1'b1;
        elapsed    = now - last_report_ts;
        if (elapsed >= TIME_W'(report_interval)) begin
          last_report_ts = now;
          r.report       = 1'b1;
        end
      end
    end
    r.distinct = USED_W'(used_slots);
    r.voltage  = last_volt;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    table_outcome_t exp_r;
    table_outcome_t new_r;
    if (!rst_n) begin
      used_slots      = 0;
      last_volt       = '0;
      last_report_ts  = '0;
      status_id       = STATUS_ID_RESET;
      report_interval = INTERVAL_RESET;
      expected_q.delete();
      fail_count      = 0;
      checked         = 0;
      dropped         = 0;
      reports         = 0;
      pending        <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_STATUS_ID) status_id = cfg_wdata[ID_W-1:0];
        else                            report_interval = cfg_wdata[INTERVAL_W-1:0];
      end
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $error("result strobed with no transaction outstanding");
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("status", 32'(exp_r.status), 32'(out_status));
          check_field("entry_index", 32'(exp_r.index), 32'(out_entry_index));
          check_field("entry_id", 32'(exp_r.id), 32'(out_entry_id));
          check_field("entry_count", exp_r.count, out_entry_count);
          check_field("distinct_ids", 32'(exp_r.distinct), 32'(out_distinct_ids));
          check_field("pack_voltage_deci", 32'(exp_r.voltage),
                      32'(out_pack_voltage_deci));
          check_field("voltage_captured", 32'(exp_r.captured),
                      32'(out_voltage_captured));
          check_field("voltage_report", 32'(exp_r.report), 32'(out_voltage_report));
          checked++;
          if (exp_r.status == STAT_DROPPED) dropped++;
          if (exp_r.report) reports++;
        end
      end
      if (start && !busy) begin
        predict_table_update(in_opcode, in_frame_id, in_data_length,
                             in_voltage_high_byte, in_voltage_low_byte,
                             in_timestamp_ms, in_read_index, new_r);
        expected_q.push_back(new_r);
      end
      pending <= expected_q.size();
    end
  end

endmodule

### verif/can_id_frequency_table_top_tb.sv
// ============================================================================
// can_id_frequency_table_top_tb
// Stimulus and verdict for the CAN identifier frequency table.
// ============================================================================
// A short directed sequence on an empty table covers empty reads, field
// extremes, hits, inserts and the voltage capture and report window,
// including timestamp wrap. Four random phases follow, each with its own
// status id and report interval, mixing known ids (hits, then drops once
// the table is full), status frames, reads and fresh ids.
module can_id_frequency_table_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import cidft_pkg::*;

  localparam int POOL_SIZE = 80;

  logic                  clk;
  logic                  rst_n                = 1'b0;
  logic                  cfg_we               = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index            = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata            = '0;
  logic                  start                = 1'b0;
  logic                  busy;
  logic                  in_opcode            = 1'b0;
  logic [ID_W-1:0]       in_frame_id          = '0;
  logic [DLEN_W-1:0]     in_data_length       = '0;
  logic [BYTE_W-1:0]     in_voltage_high_byte = '0;
  logic [BYTE_W-1:0]     in_voltage_low_byte  = '0;
  logic [TIME_W-1:0]     in_timestamp_ms      = '0;
  logic [IDX_W-1:0]      in_read_index        = '0;
  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [IDX_W-1:0]      out_entry_index;
  logic [ID_W-1:0]       out_entry_id;
  logic [COUNT_W-1:0]    out_entry_count;
  logic [USED_W-1:0]     out_distinct_ids;
  logic [VOLT_W-1:0]     out_pack_voltage_deci;
  logic                  out_voltage_captured;
  logic                  out_voltage_report;

  int fail_count;
  int pending;
  int checked;
  int dropped;
  int reports;

  int              idle_pct;
  logic [TIME_W-1:0] ts;
  logic [ID_W-1:0] status_id;
  logic [ID_W-1:0] id_pool [POOL_SIZE];

  can_id_frequency_table_top dut (.*);

  can_id_frequency_table_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic send_item(input opcode_t op, input logic [ID_W-1:0] fid,
                           input logic [DLEN_W-1:0] dlen,
                           input logic [BYTE_W-1:0] vhi,
                           input logic [BYTE_W-1:0] vlo,
                           input logic [TIME_W-1:0] stamp,
                           input logic [IDX_W-1:0] ridx);
    start                <= 1'b1;
    in_opcode            <= op;
    in_frame_id          <= fid;
    in_data_length       <= dlen;
    in_voltage_high_byte <= vhi;
    in_voltage_low_byte  <= vlo;
    in_timestamp_ms      <= stamp;
    in_read_index        <= ridx;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic rand_item();
    int                pick;
    opcode_t           op;
    logic [ID_W-1:0]   fid;
    logic [DLEN_W-1:0] dlen;
    pick = $urandom_range(99);
    if ($urandom_range(19) == 0) ts = $urandom();
    else if ($urandom_range(9) == 0) ts = ts + $urandom_range(0, 200000);
    else ts = ts + $urandom_range(0, 1000);
    op   = OP_RECORD;
    fid  = ID_W'($urandom());
    dlen = DLEN_W'($urandom_range(0, 15));
    if (pick < 15) begin
      op = OP_READ;
    end else if (pick < 35) begin
      fid = status_id;
      if ($urandom_range(3) != 0) dlen = DLEN_W'($urandom_range(4, 8));
    end else if (pick < 88) begin
      fid = id_pool[$urandom_range(POOL_SIZE - 1)];
    end
    send_item(op, fid, dlen, BYTE_W'($urandom()), BYTE_W'($urandom()), ts,
              IDX_W'($urandom()));
  endtask

  initial begin
    int n_items;
    idle_pct  = 20;
    ts        = '0;
    status_id = STATUS_ID_RESET;
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = ID_W'($urandom());
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, capture window with wrap
    send_item(OP_READ,   29'h0,        4'd0,  8'h00, 8'h00, 32'h0,        6'd0);
    send_item(OP_READ,   29'h0,        4'd0,  8'h00, 8'h00, 32'h0,        6'd63);
    send_item(OP_RECORD, 29'h0,        4'd0,  8'h00, 8'h00, 32'h0,        6'd0);
    send_item(OP_RECORD, 29'h1FFFFFFF, 4'd8,  8'hFF, 8'h00, 32'h10,       6'd63);
    send_item(OP_RECORD, 29'h0,        4'd15, 8'h5A, 8'hA5, 32'h20,       6'd0);
    send_item(OP_RECORD, 29'hE000,     4'd4,  8'h12, 8'h34, 32'd100,      6'd0);
    send_item(OP_RECORD, 29'hE000,     4'd3,  8'h77, 8'h88, 32'd700,      6'd0);
    send_item(OP_RECORD, 29'hE000,     4'd15, 8'hFF, 8'hFF, 32'd700,      6'd0);
    send_item(OP_RECORD, 29'hE000,     4'd8,  8'h00, 8'h00, 32'hFFFFFFFF, 6'd0);
    send_item(OP_RECORD, 29'hE000,     4'd4,  8'hAB, 8'hCD, 32'h100,      6'd0);
    send_item(OP_RECORD, 29'hE000,     4'd4,  8'h01, 8'h02, 32'h2F3,      6'd0);
    send_item(OP_RECORD, 29'hE001,     4'd8,  8'h03, 8'h04, 32'h2F4,      6'd0);
    send_item(OP_READ,   29'h1FFFFFFF, 4'd15, 8'hFF, 8'hFF, 32'hFFFFFFFF, 6'd0);
    send_item(OP_READ,   29'h0,        4'd0,  8'h00, 8'h00, 32'h0,        6'd2);
    send_item(OP_READ,   29'h0,        4'd0,  8'h00, 8'h00, 32'h0,        6'd3);
    send_item(OP_READ,   29'h0,        4'd0,  8'h00, 8'h00, 32'h0,        6'd4);
    ts = 32'h2F4;

    for (int phase = 0; phase < 4; phase++) begin
      wait_drain();
      case (phase)
        0: begin
          status_id = id_pool[0];
          write_cfg(CFG_REPORT_INTERVAL, CFG_DATA_W'(0));
          idle_pct = 20;
          n_items  = 400;
        end
        1: begin
          status_id = 29'h1FFFFFFF;
          write_cfg(CFG_REPORT_INTERVAL, CFG_DATA_W'(16'hFFFF));
          idle_pct = 85;
          n_items  = 400;
        end
        2: begin
          status_id = ID_W'($urandom());
          write_cfg(CFG_REPORT_INTERVAL, CFG_DATA_W'($urandom_range(1, 65534)));
          idle_pct = 0;
          n_items  = 350;
        end
        default: begin
          status_id = '0;
          write_cfg(CFG_REPORT_INTERVAL, CFG_DATA_W'(1));
          idle_pct = 0;
          n_items  = 350;
        end
      endcase
      write_cfg(CFG_STATUS_ID, status_id);
      for (int k = 0; k < n_items; k++) begin
        rand_item();
        idle_gap();
      end
    end

    wait_drain();
    repeat (80) @(posedge clk);
    if (pending != 0) $error("%0d results never arrived", pending);
    $display("checked %0d results over four register settings after directed cases",
             checked);
    $display("table overflow drops: %0d, voltage reports raised: %0d", dropped, reports);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
